>>> rtl/sad_pkg.sv
// sad_pkg: shared field widths, command, status and register codes, and the
// configuration struct of the slot allocator with deferred free
// no dependencies
package sad_pkg;

  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned FRAME_W    = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLOT_OUT_W = 10;
  localparam int unsigned REL_W      = 11;
  localparam int unsigned CAP_W      = 11;
  localparam int unsigned ESIZE_W    = 9;
  localparam int unsigned CFG_IDX_W  = 3;

  // reset stride in bytes
  localparam logic [ESIZE_W-1:0] ESIZE_RST = 9'd32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BAD_ADDR = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_REJECT   = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY   = 3'd0,
    CFG_ENTRY_SIZE = 3'd1,
    CFG_CPU_BASE   = 3'd2,
    CFG_GPU_BASE   = 3'd3,
    CFG_VISIBLE    = 3'd4
  } cfg_idx_e;

  // configuration seen by the allocator core
  typedef struct packed {
    logic              reinit;
    logic              visible;
    logic [ESIZE_W-1:0] stride;
    logic [ADDR_W-1:0] cpu_base;
    logic [ADDR_W-1:0] gpu_base;
  } cfg_t;

endpackage

>>> rtl/sad_if.sv
// sad_if: valid/ready channel interfaces for requests, responses and
// configuration writes; depends on sad_pkg for field widths
interface sad_req_if;
  logic                          valid;
  logic                          ready;
  logic [sad_pkg::CMD_W-1:0]     cmd;
  logic [sad_pkg::ADDR_W-1:0]    handle_addr;
  logic [sad_pkg::FRAME_W-1:0]   frame;

  modport source (output valid, cmd, handle_addr, frame, input ready);
  modport sink   (input valid, cmd, handle_addr, frame, output ready);
endinterface

interface sad_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [sad_pkg::STATUS_W-1:0]   status;
  logic [sad_pkg::SLOT_OUT_W-1:0] slot_index;
  logic [sad_pkg::ADDR_W-1:0]     cpu_addr;
  logic [sad_pkg::ADDR_W-1:0]     gpu_addr;
  logic [sad_pkg::REL_W-1:0]      released_count;

  modport source (output valid, status, slot_index, cpu_addr, gpu_addr, released_count,
                  input ready);
  modport sink   (input valid, status, slot_index, cpu_addr, gpu_addr, released_count,
                  output ready);
endinterface

interface sad_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sad_pkg::CFG_IDX_W-1:0] index;
  logic [sad_pkg::ADDR_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/sad_cfg.sv
// sad_cfg: configuration registers with capacity and stride clamping, and the
// registered byte limit of the table; depends on sad_pkg and sad_cfg_if
module sad_cfg #(
  parameter int unsigned MAX_SLOTS = 1024,
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1),
  localparam int unsigned LW = CW + sad_pkg::ESIZE_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  sad_cfg_if.sink         cfg_i,
  output sad_pkg::cfg_t   cfg_o,
  output logic [CW-1:0]   cap_o,
  output logic [LW-1:0]   limit_o
);

  localparam logic [CW-1:0] CAP_RST = CW'((MAX_SLOTS < 1024) ? MAX_SLOTS : 1024);

  logic [CW-1:0]                   cap_q, cap_d;
  logic [sad_pkg::ESIZE_W-1:0]     stride_q, stride_d;
  logic [sad_pkg::ADDR_W-1:0]      cpu_base_q, cpu_base_d;
  logic [sad_pkg::ADDR_W-1:0]      gpu_base_q, gpu_base_d;
  logic                            visible_q, visible_d;
  logic [LW-1:0]                   limit_q, limit_d;
  logic                            we;
  logic                            cap_we;
  logic [sad_pkg::CAP_W-1:0]       cap_raw;
  logic [sad_pkg::ESIZE_W-1:0]     esize_raw;

  assign cfg_i.ready = 1'b1;
  assign we          = cfg_i.valid && cfg_i.ready;
  assign cap_raw     = cfg_i.data[sad_pkg::CAP_W-1:0];
  assign esize_raw   = cfg_i.data[sad_pkg::ESIZE_W-1:0];

  // register decode, zero capacity acts as one, zero stride acts as one
  always_comb begin
    cap_d      = cap_q;
    stride_d   = stride_q;
    cpu_base_d = cpu_base_q;
    gpu_base_d = gpu_base_q;
    visible_d  = visible_q;
    cap_we     = 1'b0;
    if (we) begin
      unique case (sad_pkg::cfg_idx_e'(cfg_i.index))
        sad_pkg::CFG_CAPACITY: begin
          cap_we = 1'b1;
          if (cap_raw == '0) begin
            cap_d = CW'(1);
          end else if (32'(cap_raw) > MAX_SLOTS) begin
            cap_d = CW'(MAX_SLOTS);
          end else begin
            cap_d = CW'(cap_raw);
          end
        end
        sad_pkg::CFG_ENTRY_SIZE: begin
          stride_d = (esize_raw == '0) ? sad_pkg::ESIZE_W'(1) : esize_raw;
        end
        sad_pkg::CFG_CPU_BASE: cpu_base_d = cfg_i.data;
        sad_pkg::CFG_GPU_BASE: gpu_base_d = cfg_i.data;
        sad_pkg::CFG_VISIBLE:  visible_d  = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // table size in bytes, registered from the capacity and stride registers
  assign limit_d = LW'(cap_q) * LW'(stride_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= CAP_RST;
      stride_q   <= sad_pkg::ESIZE_RST;
      cpu_base_q <= '0;
      gpu_base_q <= '0;
      visible_q  <= 1'b0;
      limit_q    <= LW'(CAP_RST) * LW'(sad_pkg::ESIZE_RST);
    end else begin
      cap_q      <= cap_d;
      stride_q   <= stride_d;
      cpu_base_q <= cpu_base_d;
      gpu_base_q <= gpu_base_d;
      visible_q  <= visible_d;
      limit_q    <= limit_d;
    end
  end

  assign cfg_o.reinit   = cap_we;
  assign cfg_o.visible  = visible_q;
  assign cfg_o.stride   = stride_q;
  assign cfg_o.cpu_base = cpu_base_q;
  assign cfg_o.gpu_base = gpu_base_q;
  assign cap_o          = cap_q;
  assign limit_o        = limit_q;

endmodule

>>> rtl/sad_div.sv
// sad_div: restoring divider, one quotient bit per cycle, that turns a byte
// offset into a slot number and a remainder; depends on sad_pkg
module sad_div #(
  parameter int unsigned SLOT_W = 10,
  parameter int unsigned DIVD_W = 20,
  localparam int unsigned CNT_W = $clog2(SLOT_W + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DIVD_W-1:0]           dividend_i,
  input  logic [sad_pkg::ESIZE_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [SLOT_W-1:0]           quot_o,
  output logic [sad_pkg::ESIZE_W-1:0] rem_o
);

  logic [DIVD_W-1:0] rem_q, rem_d;
  logic [DIVD_W-1:0] dvs_q, dvs_d;
  logic [SLOT_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              ge;

  assign ge = (rem_q >= dvs_q);

  // the dividend is below divisor * 2^SLOT_W, so SLOT_W steps suffice
  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      dvs_d  = DIVD_W'(divisor_i) << (SLOT_W - 1);
      quot_d = '0;
      cnt_d  = CNT_W'(SLOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dvs_q;
      end
      quot_d = (quot_q << 1) | SLOT_W'(ge);
      dvs_d  = dvs_q >> 1;
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dvs_q  <= '0;
      quot_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      quot_q <= quot_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = sad_pkg::ESIZE_W'(rem_q);

endmodule

>>> rtl/slot_allocator_deferred_free_top.sv
// Slot allocator with per-frame deferred free, top level: control sequencer,
// free stack memory and deferred list memory; depends on sad_pkg, sad_if,
// sad_cfg and sad_div
//
// One request is worked on at a time; the response goes to an output register,
// so the next request is taken while a response still waits. Rejected
// requests (table full, empty handle, bad frame, unknown command) go straight
// to the output; an allocate passes through stack read, offset multiply, base
// add and output; a free passes through the base subtract, the range check and
// the one-bit-per-cycle divider that turns the byte offset into a slot; a frame
// release reads the queued slots through the single read port of the deferred
// list memory, one slot per cycle.
// The free stack needs no clearing pass: a high-water mark makes entries never
// written since the last capacity write read as their own index. Writing the
// capacity register resets the allocator; the deferred list memory has no
// reset and only entries below a frame's count are ever read.
module slot_allocator_deferred_free_top #(
  parameter int unsigned MAX_SLOTS = 1024,
  parameter int unsigned FRAMES    = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sad_cfg_if.sink    cfg_i,
  sad_req_if.sink    req_i,
  sad_rsp_if.source  rsp_o
);

  localparam int unsigned SW  = $clog2(MAX_SLOTS);
  localparam int unsigned CW  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned LW  = CW + sad_pkg::ESIZE_W;
  localparam int unsigned OW  = SW + sad_pkg::ESIZE_W;
  localparam int unsigned EF  = (FRAMES < 4) ? FRAMES : 4;
  localparam int unsigned FIW = (EF > 1) ? $clog2(EF) : 1;
  localparam int unsigned LD  = EF * MAX_SLOTS;
  localparam int unsigned AW  = $clog2(LD);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ALOOK = 8'b0000_0010,
    S_AADD  = 8'b0000_0100,
    S_FSUB  = 8'b0000_1000,
    S_FRNG  = 8'b0001_0000,
    S_FDIV  = 8'b0010_0000,
    S_REL   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  // deferred list address of entry n of frame f
  function automatic logic [AW-1:0] lst_addr(input logic [FIW-1:0] f,
                                             input logic [CW-1:0] n);
    return AW'(32'(f) * MAX_SLOTS + 32'(n));
  endfunction

  sad_pkg::cfg_t   cfg;
  logic [CW-1:0]   cap;
  logic [LW-1:0]   limit;

  state_e                       state_q, state_d;
  logic [CW-1:0]                ac_q, ac_d;
  logic [CW-1:0]                hw_q, hw_d;
  logic [CW-1:0]                pend_q, pend_d;
  logic [CW-1:0]                dcnt_q [EF];
  logic [CW-1:0]                dcnt_d [EF];
  logic [sad_pkg::ADDR_W-1:0]   addr_q, addr_d;
  logic [sad_pkg::FRAME_W-1:0]  frame_q, frame_d;
  logic                         fresh_q, fresh_d;
  logic [OW-1:0]                off_q, off_d;
  logic [SW-1:0]                slot_q, slot_d;
  logic [sad_pkg::ADDR_W-1:0]   diff_q, diff_d;
  logic [CW-1:0]                n_q, n_d;
  logic [CW-1:0]                rel_idx_q, rel_idx_d;
  logic                         rd_vld_q, rd_vld_d;
  logic [CW-1:0]                rel_cnt_q, rel_cnt_d;
  sad_pkg::status_e             res_status_q, res_status_d;
  logic [sad_pkg::ADDR_W-1:0]   res_cpu_q, res_cpu_d;
  logic [sad_pkg::ADDR_W-1:0]   res_gpu_q, res_gpu_d;

  logic                           out_vld_q, out_vld_d;
  sad_pkg::status_e               out_status_q, out_status_d;
  logic [sad_pkg::SLOT_OUT_W-1:0] out_slot_q, out_slot_d;
  logic [sad_pkg::ADDR_W-1:0]     out_cpu_q, out_cpu_d;
  logic [sad_pkg::ADDR_W-1:0]     out_gpu_q, out_gpu_d;
  logic [sad_pkg::REL_W-1:0]      out_rel_q, out_rel_d;

  // memories and their ports
  logic [SW-1:0]  stack_mem [MAX_SLOTS];
  logic [SW-1:0]  list_mem  [LD];
  logic           stk_we;
  logic [SW-1:0]  stk_waddr, stk_raddr, stk_wdata, stk_rdata_q;
  logic           lst_we;
  logic [AW-1:0]  lst_waddr, lst_raddr;
  logic [SW-1:0]  lst_wdata, lst_rdata_q;

  logic                         accept;
  logic [FIW-1:0]               fidx_in, fidx;
  logic [SW-1:0]                slot_sel;
  logic [sad_pkg::ADDR_W:0]     sub_full;
  logic                         issue;
  logic                         div_start, div_done;
  logic [SW-1:0]                div_quot;
  logic [sad_pkg::ESIZE_W-1:0]  div_rem;

  sad_cfg #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .cfg_o   (cfg),
    .cap_o   (cap),
    .limit_o (limit)
  );

  sad_div #(
    .SLOT_W (SW),
    .DIVD_W (LW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff_q[LW-1:0]),
    .divisor_i  (cfg.stride),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign fidx_in     = req_i.frame[FIW-1:0];
  assign fidx        = frame_q[FIW-1:0];
  assign slot_sel    = fresh_q ? SW'(ac_q) : stk_rdata_q;
  assign sub_full    = {1'b0, addr_q} - {1'b0, cfg.cpu_base};
  assign issue       = (rel_idx_q < n_q) && (ac_q != CW'(rd_vld_q));

  // memory port addresses
  assign stk_raddr = SW'(ac_q);
  assign stk_waddr = SW'(ac_q - CW'(1));
  assign stk_wdata = lst_rdata_q;
  assign lst_waddr = lst_addr(fidx, dcnt_q[fidx]);
  assign lst_raddr = lst_addr(fidx, rel_idx_q);
  assign lst_wdata = div_quot;

  // sequencer
  always_comb begin
    state_d      = state_q;
    ac_d         = ac_q;
    hw_d         = hw_q;
    pend_d       = pend_q;
    dcnt_d       = dcnt_q;
    addr_d       = addr_q;
    frame_d      = frame_q;
    fresh_d      = fresh_q;
    off_d        = off_q;
    slot_d       = slot_q;
    diff_d       = diff_q;
    n_d          = n_q;
    rel_idx_d    = rel_idx_q;
    rd_vld_d     = rd_vld_q;
    rel_cnt_d    = rel_cnt_q;
    res_status_d = res_status_q;
    res_cpu_d    = res_cpu_q;
    res_gpu_d    = res_gpu_q;
    out_vld_d    = out_vld_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_cpu_d    = out_cpu_q;
    out_gpu_d    = out_gpu_q;
    out_rel_d    = out_rel_q;
    stk_we       = 1'b0;
    lst_we       = 1'b0;
    div_start    = 1'b0;

    // response transfer frees the output register
    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          addr_d       = req_i.handle_addr;
          frame_d      = req_i.frame;
          slot_d       = '0;
          rel_cnt_d    = '0;
          res_cpu_d    = '0;
          res_gpu_d    = '0;
          res_status_d = sad_pkg::ST_OK;
          unique case (sad_pkg::cmd_e'(req_i.cmd))
            sad_pkg::CMD_ALLOC: begin
              if (ac_q >= cap) begin
                res_status_d = sad_pkg::ST_FULL;
                state_d      = S_OUT;
              end else begin
                fresh_d = (ac_q >= hw_q);
                state_d = S_ALOOK;
              end
            end
            sad_pkg::CMD_FREE: begin
              if (req_i.handle_addr == '0) begin
                res_status_d = sad_pkg::ST_EMPTY;
                state_d      = S_OUT;
              end else if (32'(req_i.frame) >= FRAMES) begin
                res_status_d = sad_pkg::ST_REJECT;
                state_d      = S_OUT;
              end else begin
                state_d = S_FSUB;
              end
            end
            sad_pkg::CMD_RELEASE: begin
              if (32'(req_i.frame) >= FRAMES) begin
                res_status_d = sad_pkg::ST_REJECT;
                state_d      = S_OUT;
              end else begin
                n_d       = dcnt_q[fidx_in];
                rel_idx_d = '0;
                rd_vld_d  = 1'b0;
                state_d   = S_REL;
              end
            end
            default: begin
              res_status_d = sad_pkg::ST_REJECT;
              state_d      = S_OUT;
            end
          endcase
        end
      end

      // pop: stack data arrives, scale the slot by the stride
      S_ALOOK: begin
        slot_d = slot_sel;
        off_d  = OW'(slot_sel) * OW'(cfg.stride);
        ac_d   = ac_q + CW'(1);
        if (fresh_q) begin
          hw_d = ac_q + CW'(1);
        end
        state_d = S_AADD;
      end

      S_AADD: begin
        res_cpu_d = cfg.cpu_base + sad_pkg::ADDR_W'(off_q);
        res_gpu_d = cfg.visible ? (cfg.gpu_base + sad_pkg::ADDR_W'(off_q)) : '0;
        state_d   = S_OUT;
      end

      // free: offset from the base, below-base check
      S_FSUB: begin
        if (sub_full[sad_pkg::ADDR_W]) begin
          res_status_d = sad_pkg::ST_BAD_ADDR;
          state_d      = S_OUT;
        end else begin
          diff_d  = sub_full[sad_pkg::ADDR_W-1:0];
          state_d = S_FRNG;
        end
      end

      // beyond the table means slot at or above capacity
      S_FRNG: begin
        if (diff_q >= sad_pkg::ADDR_W'(limit)) begin
          res_status_d = sad_pkg::ST_BAD_ADDR;
          state_d      = S_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = S_FDIV;
        end
      end

      // misalignment, over-free, then queue on the frame's list
      S_FDIV: begin
        if (div_done) begin
          if (div_rem != '0) begin
            res_status_d = sad_pkg::ST_BAD_ADDR;
          end else begin
            slot_d = div_quot;
            if (pend_q >= ac_q) begin
              res_status_d = sad_pkg::ST_REJECT;
            end else begin
              lst_we       = 1'b1;
              dcnt_d[fidx] = dcnt_q[fidx] + CW'(1);
              pend_d       = pend_q + CW'(1);
            end
          end
          state_d = S_OUT;
        end
      end

      // release: read one list entry per cycle, push the previous one
      S_REL: begin
        if (rd_vld_q) begin
          stk_we    = 1'b1;
          ac_d      = ac_q - CW'(1);
          rel_cnt_d = rel_cnt_q + CW'(1);
        end
        if (issue) begin
          rel_idx_d = rel_idx_q + CW'(1);
          rd_vld_d  = 1'b1;
        end else begin
          rd_vld_d = 1'b0;
          if (!rd_vld_q) begin
            pend_d       = (pend_q >= n_q) ? (pend_q - n_q) : '0;
            dcnt_d[fidx] = '0;
            state_d      = S_OUT;
          end
        end
      end

      S_OUT: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = sad_pkg::SLOT_OUT_W'(slot_q);
          out_cpu_d    = res_cpu_q;
          out_gpu_d    = res_gpu_q;
          out_rel_d    = sad_pkg::REL_W'(rel_cnt_q);
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // capacity write restarts the allocator
    if (cfg.reinit) begin
      ac_d   = '0;
      hw_d   = '0;
      pend_d = '0;
      for (int f = 0; f < EF; f++) begin
        dcnt_d[f] = '0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ac_q      <= '0;
      hw_q      <= '0;
      pend_q    <= '0;
      rel_idx_q <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int f = 0; f < EF; f++) begin
        dcnt_q[f] <= '0;
      end
    end else begin
      state_q   <= state_d;
      ac_q      <= ac_d;
      hw_q      <= hw_d;
      pend_q    <= pend_d;
      rel_idx_q <= rel_idx_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
      dcnt_q    <= dcnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    frame_q      <= frame_d;
    fresh_q      <= fresh_d;
    off_q        <= off_d;
    slot_q       <= slot_d;
    diff_q       <= diff_d;
    n_q          <= n_d;
    rel_cnt_q    <= rel_cnt_d;
    res_status_q <= res_status_d;
    res_cpu_q    <= res_cpu_d;
    res_gpu_q    <= res_gpu_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_cpu_q    <= out_cpu_d;
    out_gpu_q    <= out_gpu_d;
    out_rel_q    <= out_rel_d;
  end

  // free stack memory
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_q <= stack_mem[stk_raddr];
  end

  // deferred list memory
  always_ff @(posedge clk_i) begin
    if (lst_we) begin
      list_mem[lst_waddr] <= lst_wdata;
    end
    lst_rdata_q <= list_mem[lst_raddr];
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.slot_index     = out_slot_q;
  assign rsp_o.cpu_addr       = out_cpu_q;
  assign rsp_o.gpu_addr       = out_gpu_q;
  assign rsp_o.released_count = out_rel_q;

endmodule
